>>> design/a51_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a51_pkg
// Shared constants, types and LFSR step functions for the A5/1 keystream
// generator.
// ----------------------------------------------------------------------------
package a51_pkg;

    localparam int A_W          = 19;
    localparam int B_W          = 22;
    localparam int C_W          = 23;
    localparam int KEY_W        = 64;
    localparam int FRAME_W      = 22;
    localparam int KEY_STEPS    = 64;
    localparam int FRAME_STEPS  = 22;
    localparam int LOAD_STEPS   = KEY_STEPS + FRAME_STEPS;
    localparam int CLK_BIT_A    = 8;
    localparam int CLK_BIT_B    = 10;
    localparam int CLK_BIT_C    = 10;
    localparam int CFG_IDX_W    = 8;
    localparam int WARMUP_CLOCKS_DEF = 100;

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(308);

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BITS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS = CFG_IDX_W'(1);

    // controller -> datapath
    typedef struct packed {
        logic clear;      // zero the registers, start the load count
        logic load_step;  // plain clock with key/frame bit folded in
        logic warm_step;  // majority clock, no output
        logic emit;       // output bit then majority clock
    } a51_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic keyed;
        logic load_done;  // this load step is the last one
        logic warm_done;  // this warm-up step is the last one
        logic out_free;   // output register can take a bit this cycle
    } a51_status_t;

    function automatic logic [A_W-1:0] step_a(input logic [A_W-1:0] x);
        step_a = {x[A_W-2:0], x[18] ^ x[17] ^ x[16] ^ x[13]};
    endfunction

    function automatic logic [B_W-1:0] step_b(input logic [B_W-1:0] x);
        step_b = {x[B_W-2:0], x[21] ^ x[20]};
    endfunction

    function automatic logic [C_W-1:0] step_c(input logic [C_W-1:0] x);
        step_c = {x[C_W-2:0], x[22] ^ x[21] ^ x[20] ^ x[7]};
    endfunction

endpackage
`default_nettype wire

>>> design/a51_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a51_ctrl
// Sequencer: input handshake, key/frame load and warm-up phases.
// ----------------------------------------------------------------------------
module a51_ctrl
    import a51_pkg::*;
#(
    parameter int WARMUP_CLOCKS = WARMUP_CLOCKS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        restart,
    input  wire a51_status_t status,
    output a51_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_WARM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    localparam bit SKIP_WARM = (WARMUP_CLOCKS == 0);

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (restart || !status.keyed)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_step = 1'b1;
                if (status.load_done)
                begin
                    state_next = SKIP_WARM ? ST_EMIT : ST_WARM;
                end
            end
            ST_WARM:
            begin
                cmd.warm_step = 1'b1;
                if (status.warm_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // wait for room if the previous bit is still held
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> design/a51_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a51_datapath
// Three LFSRs, step counter, configuration registers and output register.
// ----------------------------------------------------------------------------
module a51_datapath
    import a51_pkg::*;
#(
    parameter int WARMUP_CLOCKS = WARMUP_CLOCKS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data,
    input  wire a51_cmd_t             cmd,
    output a51_status_t               status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      keystream_bit
);

    localparam int CNT_MAX = (WARMUP_CLOCKS > LOAD_STEPS) ? WARMUP_CLOCKS : LOAD_STEPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [KEY_W-1:0]   key_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [A_W-1:0]     a_reg, a_next;
    logic [B_W-1:0]     b_reg, b_next;
    logic [C_W-1:0]     c_reg, c_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               keyed_reg, keyed_next;
    logic               valid_reg, valid_next;
    logic               bit_reg, bit_next;

    logic [6:0]         load_idx;
    logic [4:0]         frame_idx;
    logic               load_bit;
    logic               maj;
    logic               ca, cb, cc;

    assign load_idx  = cnt_reg[6:0];
    assign frame_idx = 5'(load_idx - 7'(KEY_STEPS));
    assign load_bit  = (load_idx < 7'(KEY_STEPS)) ? key_reg[load_idx[5:0]]
                                                  : frame_reg[frame_idx];

    assign ca  = a_reg[CLK_BIT_A];
    assign cb  = b_reg[CLK_BIT_B];
    assign cc  = c_reg[CLK_BIT_C];
    assign maj = (ca & cb) | (ca & cc) | (cb & cc);

    assign status.keyed     = keyed_reg;
    assign status.load_done = (cnt_reg == CNT_W'(LOAD_STEPS - 1));
    assign status.warm_done = (WARMUP_CLOCKS != 0) && (cnt_reg == CNT_W'(WARMUP_CLOCKS - 1));
    assign status.out_free  = !valid_reg || m_tready;

    assign m_tvalid      = valid_reg;
    assign keystream_bit = bit_reg;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        keyed_next = keyed_reg;
        valid_next = valid_reg && !m_tready;
        bit_next   = bit_reg;

        if (cmd.clear)
        begin
            a_next   = '0;
            b_next   = '0;
            c_next   = '0;
            cnt_next = '0;
        end
        else if (cmd.load_step)
        begin
            a_next   = step_a(a_reg) ^ A_W'(load_bit);
            b_next   = step_b(b_reg) ^ B_W'(load_bit);
            c_next   = step_c(c_reg) ^ C_W'(load_bit);
            // counter restarts for the warm-up phase
            cnt_next = status.load_done ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.warm_step || cmd.emit)
        begin
            if (ca == maj) a_next = step_a(a_reg);
            if (cb == maj) b_next = step_b(b_reg);
            if (cc == maj) c_next = step_c(c_reg);
            if (cmd.warm_step)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                bit_next   = a_reg[A_W-1] ^ b_reg[B_W-1] ^ c_reg[C_W-1];
                valid_next = 1'b1;
                keyed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            frame_reg <= FRAME_RESET;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            cnt_reg   <= '0;
            keyed_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_KEY_BITS))
            begin
                key_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_FRAME_BITS))
            begin
                frame_reg <= cfg_data[FRAME_W-1:0];
            end
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            cnt_reg   <= cnt_next;
            keyed_reg <= keyed_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

endmodule
`default_nettype wire

>>> design/a5_1_keystream_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a5_1_keystream_generator
// A5/1 keystream generator with stream input/output and a register port.
// ----------------------------------------------------------------------------
// Each input transfer returns one keystream bit. A plain item is emitted
// straight from idle, so bits flow at one per cycle while the output side
// keeps up; the input is held off while a bit waits in the output register
// and is not taken in that cycle, and while an item loads, warms up or waits
// to emit. An item with restart set, or the first item after reset, first
// clears the three LFSRs, loads 64 key and 22 frame bits one per cycle, then
// runs WARMUP_CLOCKS majority clocks one per cycle before its bit is emitted.
// Key and frame registers are read at load time only; cfg_ready is always
// high.
module a5_1_keystream_generator
    import a51_pkg::*;
#(
    parameter int WARMUP_CLOCKS = WARMUP_CLOCKS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] restart, [7:1] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [0] keystream_bit, [7:1] zero
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data
);

    a51_cmd_t    cmd;
    a51_status_t status;
    logic        keystream_bit;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'b0, keystream_bit};

    a51_ctrl #(
        .WARMUP_CLOCKS (WARMUP_CLOCKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .status   (status),
        .cmd      (cmd)
    );

    a51_datapath #(
        .WARMUP_CLOCKS (WARMUP_CLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .keystream_bit (keystream_bit)
    );

    // a new bit never overwrites one still waiting
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("emit while output register is held");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load_step, cmd.warm_step, cmd.emit}))
        else $error("more than one datapath command");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("output valid without emit");

    // no input transfer while loading or warming up
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_step || cmd.warm_step) |-> !s_tready)
        else $error("input ready during load or warm-up");

endmodule
`default_nettype wire
